// ===== design/rmsd_pkg.sv =====
package rmsd_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned DWordW = 64;
  localparam int unsigned IdxW = 4;
  localparam int unsigned ModeW = 2;
  localparam int unsigned InUserW = 8;
  localparam int unsigned StepCntW = $clog2(DWordW);

  localparam logic [IdxW-1:0] REG_CTRL = 4'd0;
  localparam logic [IdxW-1:0] REG_NUM_LO = 4'd1;
  localparam logic [IdxW-1:0] REG_NUM_HI = 4'd2;
  localparam logic [IdxW-1:0] REG_DEN_LO = 4'd3;
  localparam logic [IdxW-1:0] REG_DEN_HI = 4'd4;
  localparam logic [IdxW-1:0] REG_QUO_LO = 4'd5;
  localparam logic [IdxW-1:0] REG_QUO_HI = 4'd6;
  localparam logic [IdxW-1:0] REG_REM_LO = 4'd7;
  localparam logic [IdxW-1:0] REG_REM_HI = 4'd8;

  localparam logic CMD_READ = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [ModeW-1:0] MODE_32 = 2'd0;
  localparam logic [ModeW-1:0] MODE_64_32 = 2'd1;
  localparam logic [ModeW-1:0] MODE_64 = 2'd2;
  localparam logic [ModeW-1:0] MODE_32_ALT = 2'd3;

  localparam int unsigned CtrlZeroBit = 14;
  localparam int unsigned CtrlBusyBit = 15;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_ITER,
    DIV_FIX
  } div_state_e;

  typedef enum logic {
    CTL_IDLE,
    CTL_BUSY
  } ctl_state_e;

  typedef struct packed {
    logic              start;
    logic [DWordW-1:0] num;
    logic [DWordW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DWordW-1:0] quo;
    logic [DWordW-1:0] rem;
  } div_rsp_t;

endpackage

// ===== design/register_mapped_signed_divider.sv =====
// Channel  | Direction | tdata                  | tuser
// s_axis   | in        | [31:0] write_data      | [0] command, [4:1] reg_index, [7:5] zero
// m_axis   | out       | [31:0] read_data       | [0] bad_access
//
// A read or a rejected write answers from the output register.
// A write to control, numerator or denominator answers at once, then runs the
// one-bit-per-cycle restoring divider: 1 load, 64 steps, 1 sign fix; no new beat
// is taken until the divider is done.
// Reset clears all registers, the divider control and the output valid flag.
// A stalled output holds its beat and blocks the input side.
module register_mapped_signed_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rmsd_pkg::WordW-1:0]    s_axis_tdata,  // write_data
  input  logic [rmsd_pkg::InUserW-1:0]  s_axis_tuser,  // command, reg_index, padding
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [rmsd_pkg::WordW-1:0]    m_axis_tdata,  // read_data
  output logic                          m_axis_tuser   // bad_access
);
  import rmsd_pkg::*;

  ctl_state_e state_q, state_d;
  logic [ModeW-1:0] mode_q;
  logic [DWordW-1:0] num_q, den_q, quo_q, rem_q;
  logic zero_q;
  logic start_q;
  logic out_valid_q;
  logic [WordW-1:0] out_data_q;
  logic out_bad_q;

  logic cmd;
  logic [IdxW-1:0] idx;
  logic in_acc;
  logic wr_ok;
  logic [WordW-1:0] rd_data;
  logic rd_bad;
  logic mode32;
  logic [DWordW-1:0] num_sx, den_sx;
  div_req_t req;
  div_rsp_t rsp;

  assign cmd = s_axis_tuser[0];
  assign idx = s_axis_tuser[IdxW:1];
  assign s_axis_tready = (state_q == CTL_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign wr_ok = (cmd == CMD_WRITE) && (idx <= REG_DEN_HI);
  assign mode32 = (mode_q == MODE_32) || (mode_q == MODE_32_ALT);
  assign num_sx = {{WordW{num_q[WordW-1]}}, num_q[WordW-1:0]};
  assign den_sx = {{WordW{den_q[WordW-1]}}, den_q[WordW-1:0]};

  assign req.start = start_q;
  assign req.num = mode32 ? num_sx : num_q;
  assign req.den = (mode_q == MODE_64) ? den_q : den_sx;

  rmsd_serial_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  always_comb begin
    rd_data = '0;
    rd_bad = 1'b0;
    if (cmd == CMD_READ) begin
      unique case (idx)
        REG_CTRL: begin
          rd_data[ModeW-1:0] = mode_q;
          rd_data[CtrlZeroBit] = zero_q;
          rd_data[CtrlBusyBit] = 1'b0;
        end
        REG_QUO_LO: rd_data = quo_q[WordW-1:0];
        REG_QUO_HI: rd_data = quo_q[DWordW-1:WordW];
        REG_REM_LO: rd_data = rem_q[WordW-1:0];
        REG_REM_HI: rd_data = rem_q[DWordW-1:WordW];
        default: rd_bad = 1'b1;
      endcase
    end else begin
      rd_bad = !wr_ok;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CTL_IDLE: if (in_acc && wr_ok) state_d = CTL_BUSY;
      CTL_BUSY: if (rsp.done) state_d = CTL_IDLE;
      default: state_d = CTL_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTL_IDLE;
      start_q <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q <= '0;
      num_q <= '0;
      den_q <= '0;
      quo_q <= '0;
      rem_q <= '0;
      zero_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= in_acc && wr_ok;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc && wr_ok) begin
        unique case (idx)
          REG_CTRL: mode_q <= s_axis_tdata[ModeW-1:0];
          REG_NUM_LO: num_q[WordW-1:0] <= s_axis_tdata;
          REG_NUM_HI: num_q[DWordW-1:WordW] <= s_axis_tdata;
          REG_DEN_LO: den_q[WordW-1:0] <= s_axis_tdata;
          REG_DEN_HI: den_q[DWordW-1:WordW] <= s_axis_tdata;
          default: ;
        endcase
      end
      if (rsp.done) begin
        zero_q <= (den_q == '0);
        if (mode32 && (den_q[WordW-1:0] == '0)) begin
          quo_q <= num_q[WordW-1] ? {{WordW{1'b1}}, {(WordW-1){1'b0}}, 1'b1}
                                  : {{WordW{1'b0}}, {WordW{1'b1}}};
          rem_q <= rsp.rem;
        end else if (mode32 && (num_q[WordW-1:0] == {1'b1, {(WordW-1){1'b0}}})
                     && (den_q[WordW-1:0] == '1)) begin
          quo_q <= {{(WordW+1){1'b0}}, {(WordW-1){1'b0}}} | {{WordW{1'b0}}, 1'b1,
                   {(WordW-1){1'b0}}};
          rem_q <= '0;
        end else begin
          quo_q <= rsp.quo;
          rem_q <= rsp.rem;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= rd_data;
      out_bad_q <= rd_bad;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_data_q;
  assign m_axis_tuser = out_bad_q;

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (state_q == CTL_IDLE))
    else $error("input ready while a division runs");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> (state_q == CTL_BUSY))
    else $error("divider finished outside a recompute");
  a_start_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && wr_ok) |=> (start_q && (state_q == CTL_BUSY)))
    else $error("write did not launch a recompute");
  a_operands_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == CTL_BUSY) && $past(state_q == CTL_BUSY)) |->
      ($stable(num_q) && $stable(den_q) && $stable(mode_q)))
    else $error("operands changed during a division");
`endif

endmodule

// ===== design/rmsd_serial_div.sv =====
module rmsd_serial_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rmsd_pkg::div_req_t req_i,
  output rmsd_pkg::div_rsp_t rsp_o
);
  import rmsd_pkg::*;

  div_state_e state_q, state_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;
  logic [DWordW-1:0] acc_q, acc_d;
  logic [DWordW-1:0] rem_q, rem_d;
  logic [DWordW-1:0] den_q, den_d;
  logic na_q, na_d, nb_q, nb_d;
  logic [DWordW:0] trial;
  logic [DWordW:0] diff;
  logic fits;

  assign trial = {rem_q, acc_q[DWordW-1]};
  assign diff = trial - {1'b0, den_q};
  assign fits = ~diff[DWordW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    den_q <= den_d;
    na_q <= na_d;
    nb_q <= nb_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    acc_d = acc_q;
    rem_d = rem_q;
    den_d = den_q;
    na_d = na_q;
    nb_d = nb_q;
    rsp_o.done = 1'b0;
    rsp_o.quo = (na_q ^ nb_q) ? (~acc_q + 1'b1) : acc_q;
    rsp_o.rem = na_q ? (~rem_q + 1'b1) : rem_q;
    unique case (state_q)
      DIV_IDLE: begin
        if (req_i.start) begin
          na_d = req_i.num[DWordW-1];
          nb_d = req_i.den[DWordW-1];
          acc_d = req_i.num[DWordW-1] ? (~req_i.num + 1'b1) : req_i.num;
          den_d = req_i.den[DWordW-1] ? (~req_i.den + 1'b1) : req_i.den;
          rem_d = '0;
          cnt_d = '0;
          state_d = DIV_ITER;
        end
      end
      DIV_ITER: begin
        rem_d = fits ? diff[DWordW-1:0] : trial[DWordW-1:0];
        acc_d = {acc_q[DWordW-2:0], fits};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          state_d = DIV_FIX;
        end
      end
      DIV_FIX: begin
        rsp_o.done = 1'b1;
        state_d = DIV_IDLE;
      end
      default: state_d = DIV_IDLE;
    endcase
  end

endmodule
